// ===== design/irpd_pkg.sv =====
// Shared types, register indexes and widths for the pulse-distance frame decoder.
package irpd_pkg;

    localparam int IntervalW  = 17;
    localparam int CountW     = 6;
    localparam int ByteW      = 8;
    localparam int NumBytes   = 4;
    localparam int CmdByteIdx = 2;
    localparam int AddrByteIdx = 3;
    localparam int CfgIdxW    = 3;

    // Input beat layout
    localparam int SDataW = 24;
    // Output beat layout
    localparam int MDataW = 16;

    localparam int FrameBitsDefault = 32;

    // Decoupling queue; depth must be a power of two
    localparam int QueueDepth = 2;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_HEADER_MIN = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_HEADER_MAX = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_ZERO_MIN   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_ZERO_MAX   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_ONE_MIN    = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_ONE_MAX    = 3'd5;

    // Reset values of the window bounds
    localparam logic [IntervalW-1:0] HeaderMinRst = 17'd10000;
    localparam logic [IntervalW-1:0] HeaderMaxRst = 17'd20000;
    localparam logic [IntervalW-1:0] ZeroMinRst   = 17'd500;
    localparam logic [IntervalW-1:0] ZeroMaxRst   = 17'd1800;
    localparam logic [IntervalW-1:0] OneMinRst    = 17'd1800;
    localparam logic [IntervalW-1:0] OneMaxRst    = 17'd3000;

    // Classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_HEADER = 3'd1,
        OP_ONE    = 3'd2,
        OP_ZERO   = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_status;

endpackage

// ===== design/irpd_front.sv =====
// Front end: window bound registers and classification of incoming beats.
module irpd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [irpd_pkg::CfgIdxW-1:0]  i_cfg_addr,
    input  logic [irpd_pkg::IntervalW-1:0] i_cfg_data,
    input  logic                          i_kind,
    input  logic [irpd_pkg::IntervalW-1:0] i_interval,
    output irpd_pkg::t_op                 o_op
);

    logic [irpd_pkg::IntervalW-1:0] r_hdr_min, r_hdr_max;
    logic [irpd_pkg::IntervalW-1:0] r_zero_min, r_zero_max;
    logic [irpd_pkg::IntervalW-1:0] r_one_min, r_one_max;
    logic in_hdr, in_zero, in_one;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_min  <= irpd_pkg::HeaderMinRst;
            r_hdr_max  <= irpd_pkg::HeaderMaxRst;
            r_zero_min <= irpd_pkg::ZeroMinRst;
            r_zero_max <= irpd_pkg::ZeroMaxRst;
            r_one_min  <= irpd_pkg::OneMinRst;
            r_one_max  <= irpd_pkg::OneMaxRst;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                irpd_pkg::REG_HEADER_MIN: r_hdr_min  <= i_cfg_data;
                irpd_pkg::REG_HEADER_MAX: r_hdr_max  <= i_cfg_data;
                irpd_pkg::REG_ZERO_MIN:   r_zero_min <= i_cfg_data;
                irpd_pkg::REG_ZERO_MAX:   r_zero_max <= i_cfg_data;
                irpd_pkg::REG_ONE_MIN:    r_one_min  <= i_cfg_data;
                irpd_pkg::REG_ONE_MAX:    r_one_max  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Exclusive bounds on every window
    assign in_hdr  = (i_interval > r_hdr_min)  && (i_interval < r_hdr_max);
    assign in_zero = (i_interval > r_zero_min) && (i_interval < r_zero_max);
    assign in_one  = (i_interval > r_one_min)  && (i_interval < r_one_max);

    // Header wins over bit windows, one wins over zero
    always_comb begin
        if (i_kind)       o_op = irpd_pkg::OP_READ;
        else if (in_hdr)  o_op = irpd_pkg::OP_HEADER;
        else if (in_one)  o_op = irpd_pkg::OP_ONE;
        else if (in_zero) o_op = irpd_pkg::OP_ZERO;
        else              o_op = irpd_pkg::OP_NONE;
    end

endmodule

// ===== design/irpd_queue.sv =====
// Short queue of classified operations between front and back.
module irpd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  irpd_pkg::t_op        i_op,
    input  logic                 i_pop,
    output irpd_pkg::t_op        o_op,
    output irpd_pkg::t_q_status  o_status
);

    irpd_pkg::t_op r_mem [irpd_pkg::QueueDepth];
    logic [irpd_pkg::QPtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [irpd_pkg::QCntW-1:0] r_count;
    logic do_push, do_pop;

    assign o_status.full  = (r_count == irpd_pkg::QCntW'(irpd_pkg::QueueDepth));
    assign o_status.valid = (r_count != '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && o_status.valid;
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/irpd_back.sv =====
// Back end: frame state, bit shifting, code flag and the output register.
module irpd_back #(
    parameter int FRAME_BITS = irpd_pkg::FrameBitsDefault
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  irpd_pkg::t_op             i_op,
    input  irpd_pkg::t_q_status       i_q_status,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_taken,
    output logic [irpd_pkg::ByteW-1:0] o_cmd,
    output logic                      o_pending
);

    logic [irpd_pkg::ByteW-1:0] r_bytes [irpd_pkg::NumBytes];
    logic [irpd_pkg::ByteW-1:0] n_bytes [irpd_pkg::NumBytes];
    logic [irpd_pkg::CountW-1:0] r_count, n_count, count_inc;
    logic r_armed, n_armed, r_flag, n_flag;
    logic r_out_valid, r_taken, n_taken, r_pending;
    logic [irpd_pkg::ByteW-1:0] r_cmd, n_cmd;
    logic [1:0] byte_sel;
    logic bit_val;

    // Advance when the output register is free or being drained
    assign o_pop = i_q_status.valid && (!r_out_valid || i_ready);

    assign byte_sel  = r_count[4:3];
    assign bit_val   = (i_op == irpd_pkg::OP_ONE);
    assign count_inc = r_count + 1'b1;

    always_comb begin
        n_bytes = r_bytes;
        n_count = r_count;
        n_armed = r_armed;
        n_flag  = r_flag;
        n_taken = 1'b0;
        n_cmd   = '0;
        case (i_op)
            irpd_pkg::OP_READ: begin
                if (r_flag) begin
                    n_taken = 1'b1;
                    n_cmd   = r_bytes[irpd_pkg::CmdByteIdx];
                    n_flag  = 1'b0;
                end
            end
            irpd_pkg::OP_HEADER: begin
                n_armed = 1'b1;
            end
            irpd_pkg::OP_ONE, irpd_pkg::OP_ZERO: begin
                if (r_armed) begin
                    // LSB first: new bit enters at the top of the byte
                    n_bytes[byte_sel] = {bit_val, r_bytes[byte_sel][irpd_pkg::ByteW-1:1]};
                    n_count = count_inc;
                    if (count_inc >= irpd_pkg::CountW'(FRAME_BITS)) begin
                        n_flag  = ((n_bytes[irpd_pkg::CmdByteIdx] &
                                    n_bytes[irpd_pkg::AddrByteIdx]) == '0);
                        n_armed = 1'b0;
                        n_count = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < irpd_pkg::NumBytes; i++) r_bytes[i] <= '0;
            r_count     <= '0;
            r_armed     <= 1'b0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_bytes <= n_bytes;
                r_count <= n_count;
                r_armed <= n_armed;
                r_flag  <= n_flag;
            end
            if (o_pop)        r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_taken   <= n_taken;
            r_cmd     <= n_cmd;
            r_pending <= n_flag;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_taken   = r_taken;
    assign o_cmd     = r_cmd;
    assign o_pending = r_pending;

endmodule

// ===== design/ir_pulse_distance_frame_decoder_unit.sv =====
// Top level of the pulse-distance infrared frame decoder.
// Use: feed one beat per measured edge interval (tuser = 0, tdata = interval in
// microseconds) or per code read request (tuser = 1). Every input beat yields
// exactly one output beat: tuser flags a freshly taken code, tdata carries the
// command byte (zero unless taken) and the code-pending flag after that beat.
// Window bounds are written through the cfg channel; the user must write them only
// while the block is idle, which the block itself does not enforce; o_cfg_ready is always high.
// Path: the front classifies the beat and pushes it into the queue at the accepting
// edge; the back end then pops it, updates state and registers the output beat once
// the output register is free or being drained.
// Throughput: one beat per cycle while the receiver keeps tready high; the back end
// pops one queue entry per cycle.
// Stall: when the receiver holds tready low, the output register holds its beat,
// the back end stops popping and the two-entry queue absorbs the front; tready on
// the input side drops only once the queue is full.
// Reset (synchronous, active low): bounds return to their defaults, frame bytes,
// bit count, armed and pending flags clear, queue and output register empty.
module ir_pulse_distance_frame_decoder_unit #(
    parameter int FRAME_BITS = irpd_pkg::FrameBitsDefault
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [irpd_pkg::CfgIdxW-1:0]   i_cfg_addr,
    input  logic [irpd_pkg::IntervalW-1:0] i_cfg_data,
    // Input stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [irpd_pkg::SDataW-1:0]    i_s_axis_tdata,  // [16:0] interval_us, rest zero
    input  logic                           i_s_axis_tuser,  // [0] kind
    // Output stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [irpd_pkg::MDataW-1:0]    o_m_axis_tdata,  // [7:0] command_byte, [8] code_pending
    output logic                           o_m_axis_tuser   // [0] code_taken
);

    irpd_pkg::t_op       front_op, back_op;
    irpd_pkg::t_q_status q_status;
    logic                s_beat, back_pop;
    logic [irpd_pkg::ByteW-1:0] cmd;
    logic                pending;

    assign o_cfg_ready     = 1'b1;
    // Accept whenever the queue has room, independent of the output side
    assign o_s_axis_tready = !q_status.full;
    assign s_beat          = i_s_axis_tvalid && o_s_axis_tready;

    irpd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_kind     (i_s_axis_tuser),
        .i_interval (i_s_axis_tdata[irpd_pkg::IntervalW-1:0]),
        .o_op       (front_op)
    );

    irpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_beat),
        .i_op    (front_op),
        .i_pop   (back_pop),
        .o_op    (back_op),
        .o_status(q_status)
    );

    irpd_back #(
        .FRAME_BITS(FRAME_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (back_op),
        .i_q_status(q_status),
        .o_pop     (back_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_taken   (o_m_axis_tuser),
        .o_cmd     (cmd),
        .o_pending (pending)
    );

    // Pack the output beat; spare bits are zero
    assign o_m_axis_tdata = {{(irpd_pkg::MDataW - irpd_pkg::ByteW - 1){1'b0}}, pending, cmd};

`ifndef ASSERT_OFF
    // Taking a code always clears the pending flag
    a_taken_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> !o_m_axis_tdata[irpd_pkg::ByteW])
        else $error("code taken but still pending");

    // Command byte is zero on every beat that did not take a code
    a_cmd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata[irpd_pkg::ByteW-1:0] == '0))
        else $error("command byte set without a taken code");

    // An accepted beat is never lost between front and back
    a_beat_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_beat |=> q_status.valid)
        else $error("accepted beat missing from queue");
`endif

endmodule

// ===== dv/ir_pulse_distance_frame_decoder_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the pulse-distance frame decoder: scripted and random stream traffic.
module ir_pulse_distance_frame_decoder_unit_tb;

    localparam int FRAME_BITS    = irpd_pkg::FrameBitsDefault;
    localparam int IntervalW     = irpd_pkg::IntervalW;
    localparam int ByteW         = irpd_pkg::ByteW;
    localparam int CfgIdxW       = irpd_pkg::CfgIdxW;
    localparam int SDataW        = irpd_pkg::SDataW;
    localparam int MDataW        = irpd_pkg::MDataW;
    localparam int NumBytes      = irpd_pkg::NumBytes;
    localparam int CountW        = irpd_pkg::CountW;
    localparam int RST_CYCLES    = 5;
    localparam int IDLE_PCT      = 13;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 500;
    localparam int INTERVAL_TOP  = 65536;
    localparam int RANDOM_BEATS  = 420;

    // Input beat kinds, carried on tuser
    localparam logic KIND_INTERVAL = 1'b0;
    localparam logic KIND_READ     = 1'b1;

    // One set of window bounds, named after the registers they land in
    typedef struct packed {
        logic [IntervalW-1:0] hdr_lo;
        logic [IntervalW-1:0] hdr_hi;
        logic [IntervalW-1:0] zero_lo;
        logic [IntervalW-1:0] zero_hi;
        logic [IntervalW-1:0] one_lo;
        logic [IntervalW-1:0] one_hi;
    } t_windows;

    // Fields of one output beat
    typedef struct packed {
        logic             taken;
        logic [ByteW-1:0] command;
        logic             pending;
    } t_code_beat;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_valid     = 1'b0;
    logic [CfgIdxW-1:0]   i_cfg_addr      = '0;
    logic [IntervalW-1:0] i_cfg_data      = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic [SDataW-1:0]    i_s_axis_tdata  = '0;
    logic                 i_s_axis_tuser  = 1'b0;
    logic                 i_m_axis_tready = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [MDataW-1:0]    o_m_axis_tdata;
    logic                 o_m_axis_tuser;

    // Decoder state as the bench sees it, together with its copy of the windows
    t_windows         win;
    logic [ByteW-1:0] frame_byte [NumBytes];
    logic [CountW-1:0] bits_in;
    logic             frame_armed;
    logic             code_ready;

    t_code_beat code_beats_due [$];
    t_code_beat seen_due;
    int         beats_sent   = 0;
    int         err_count    = 0;
    int         stall_cycles = 0;
    bit         steady_mode  = 1'b0;

    ir_pulse_distance_frame_decoder_unit #(
        .FRAME_BITS (FRAME_BITS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),  // [16:0] interval_us, rest zero
        .i_s_axis_tuser  (i_s_axis_tuser),  // [0] kind
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // [7:0] command_byte, [8] code_pending
        .o_m_axis_tuser  (o_m_axis_tuser)   // [0] code_taken
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Receiver: drop tready now and then, never while the steady stretch runs
    always @(posedge i_clk) begin
        i_m_axis_tready <= steady_mode || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic logic in_window(input logic [IntervalW-1:0] v,
                                       input logic [IntervalW-1:0] lo,
                                       input logic [IntervalW-1:0] hi);
        return (v > lo) && (v < hi);
    endfunction

    // Advance the decoder copy by one input beat and return the beat it must emit.
    // Header test first, then the one window ahead of the zero window.
    function automatic t_code_beat next_code_beat(input logic kind,
                                                  input logic [IntervalW-1:0] iv);
        t_code_beat    beat;
        irpd_pkg::t_op op;
        logic [1:0]    slot;
        beat = '0;
        if (kind == KIND_READ)
            op = irpd_pkg::OP_READ;
        else if (in_window(iv, win.hdr_lo, win.hdr_hi))
            op = irpd_pkg::OP_HEADER;
        else if (!frame_armed)
            op = irpd_pkg::OP_NONE;
        else if (in_window(iv, win.one_lo, win.one_hi))
            op = irpd_pkg::OP_ONE;
        else if (in_window(iv, win.zero_lo, win.zero_hi))
            op = irpd_pkg::OP_ZERO;
        else
            op = irpd_pkg::OP_NONE;
        case (op)
            irpd_pkg::OP_READ: begin
                if (code_ready) begin
                    beat.taken   = 1'b1;
                    beat.command = frame_byte[irpd_pkg::CmdByteIdx];
                    code_ready   = 1'b0;
                end
            end
            irpd_pkg::OP_HEADER: frame_armed = 1'b1;
            irpd_pkg::OP_ONE, irpd_pkg::OP_ZERO: begin
                // LSB first: shift the current byte right, new bit enters at the top
                slot = bits_in[4:3];
                frame_byte[slot] = {op == irpd_pkg::OP_ONE, frame_byte[slot][ByteW-1:1]};
                bits_in = bits_in + 1'b1;
                if (bits_in >= FRAME_BITS) begin
                    code_ready  = (frame_byte[irpd_pkg::CmdByteIdx] &
                                   frame_byte[irpd_pkg::AddrByteIdx]) == '0;
                    frame_armed = 1'b0;
                    bits_in     = '0;
                end
            end
            default: ;
        endcase
        beat.pending = code_ready;
        return beat;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        err_count++;
    endtask

    // Compare every output beat with the oldest beat still due
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (code_beats_due.size() == 0) begin
                report_mismatch("unexpected beat", int'(o_m_axis_tdata), 0);
            end else begin
                seen_due = code_beats_due.pop_front();
                if (o_m_axis_tuser !== seen_due.taken)
                    report_mismatch("code_taken", int'(o_m_axis_tuser), int'(seen_due.taken));
                if (o_m_axis_tdata[ByteW-1:0] !== seen_due.command)
                    report_mismatch("command_byte", int'(o_m_axis_tdata[ByteW-1:0]),
                                    int'(seen_due.command));
                if (o_m_axis_tdata[ByteW] !== seen_due.pending)
                    report_mismatch("code_pending", int'(o_m_axis_tdata[ByteW]),
                                    int'(seen_due.pending));
            end
        end
    end

    // Watchdog: end the run once no channel has moved a beat for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Send one beat, with a random gap first outside the steady stretch; hold tvalid high afterwards so
    // back-to-back beats never see it lowered and raised in one step
    task automatic send_beat(input logic kind, input int iv);
        while (!steady_mode && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= SDataW'(iv);
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        code_beats_due.push_back(next_code_beat(kind, IntervalW'(iv)));
        beats_sent++;
    endtask

    task automatic cfg_beat(input logic [CfgIdxW-1:0] idx, input logic [IntervalW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Only call while the decoder is idle
    task automatic write_windows(input t_windows w);
        cfg_beat(irpd_pkg::REG_HEADER_MIN, w.hdr_lo);
        cfg_beat(irpd_pkg::REG_HEADER_MAX, w.hdr_hi);
        cfg_beat(irpd_pkg::REG_ZERO_MIN,   w.zero_lo);
        cfg_beat(irpd_pkg::REG_ZERO_MAX,   w.zero_hi);
        cfg_beat(irpd_pkg::REG_ONE_MIN,    w.one_lo);
        cfg_beat(irpd_pkg::REG_ONE_MAX,    w.one_hi);
        i_cfg_valid <= 1'b0;
        win = w;
    endtask

    // Drop tvalid, wait for every due beat, then let the pipeline settle
    task automatic drain_and_settle();
        i_s_axis_tvalid <= 1'b0;
        while (code_beats_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int interval_in(input int lo, input int hi);
        if (hi > lo + 1) return int'($urandom_range(lo + 1, hi - 1));
        return lo;
    endfunction

    function automatic t_windows random_windows();
        t_windows w;
        int zl, zh, ol, oh, hl, hh;
        zl = int'($urandom_range(0, 3000));
        zh = zl + int'($urandom_range(2, 1500));
        // let the one window start a little inside the zero window now and then
        ol = zh + int'($urandom_range(0, 800)) - 300;
        if (ol < 0) ol = 0;
        oh = ol + int'($urandom_range(2, 2000));
        hl = int'($urandom_range(3500, 50000));
        hh = hl + int'($urandom_range(2, 15000));
        if (hh > INTERVAL_TOP) hh = INTERVAL_TOP;
        w.hdr_lo  = IntervalW'(hl);
        w.hdr_hi  = IntervalW'(hh);
        w.zero_lo = IntervalW'(zl);
        w.zero_hi = IntervalW'(zh);
        w.one_lo  = IntervalW'(ol);
        w.one_hi  = IntervalW'(oh);
        return w;
    endfunction

    // Header then nbits data intervals; mostly the usual layout where byte 1 and
    // byte 3 are the inverse of byte 0 and byte 2, with the odd stray interval
    task automatic send_frame(input int nbits);
        logic [ByteW-1:0] fr [NumBytes];
        int               i;
        logic             b;
        fr[0] = ByteW'($urandom);
        fr[1] = ($urandom_range(0, 99) < 70) ? ~fr[0] : ByteW'($urandom);
        fr[2] = ByteW'($urandom);
        fr[3] = ($urandom_range(0, 99) < 70) ? ~fr[2] : ByteW'($urandom);
        send_beat(KIND_INTERVAL, interval_in(int'(win.hdr_lo), int'(win.hdr_hi)));
        for (i = 0; i < nbits; i++) begin
            if ($urandom_range(0, 99) < 3)
                send_beat(KIND_INTERVAL, $urandom_range(0, INTERVAL_TOP));
            b = fr[i / ByteW][i % ByteW];
            send_beat(KIND_INTERVAL, b ? interval_in(int'(win.one_lo), int'(win.one_hi))
                                       : interval_in(int'(win.zero_lo), int'(win.zero_hi)));
        end
    endtask

    // Reset windows: intervals of 0 and INTERVAL_TOP, reads with nothing pending, bounds hit
    // exactly, stray bits before arming, header while armed
    task automatic test_default_windows();
        send_beat(KIND_READ,     INTERVAL_TOP);
        send_beat(KIND_INTERVAL, 0);
        send_beat(KIND_INTERVAL, INTERVAL_TOP);
        send_beat(KIND_INTERVAL, 1000);
        send_beat(KIND_INTERVAL, int'(irpd_pkg::HeaderMinRst));
        send_beat(KIND_INTERVAL, int'(irpd_pkg::HeaderMaxRst));
        send_beat(KIND_INTERVAL, 15000);
        send_beat(KIND_INTERVAL, 2000);
        send_beat(KIND_INTERVAL, 15000);
        send_beat(KIND_INTERVAL, int'(irpd_pkg::ZeroMaxRst));
        send_beat(KIND_INTERVAL, 1000);
        send_beat(KIND_READ,     0);
    endtask

    // Header window over the one window, and one window over the zero window
    task automatic test_window_overlap();
        drain_and_settle();
        write_windows('{hdr_lo: 1000, hdr_hi: 2000, zero_lo: 400, zero_hi: 2500,
                        one_lo: 1500, one_hi: 3000});
        send_beat(KIND_INTERVAL, 1700);
        send_beat(KIND_INTERVAL, 2200);
        send_beat(KIND_INTERVAL, 450);
        send_beat(KIND_INTERVAL, 1200);
        send_beat(KIND_INTERVAL, 2600);
        send_beat(KIND_READ,     INTERVAL_TOP);
    endtask

    // Bounds at both ends of their range, then every window empty
    task automatic test_extreme_windows();
        drain_and_settle();
        write_windows('{hdr_lo: INTERVAL_TOP - 2, hdr_hi: INTERVAL_TOP, zero_lo: 0,
                        zero_hi: 2, one_lo: 0, one_hi: INTERVAL_TOP});
        send_beat(KIND_INTERVAL, INTERVAL_TOP - 1);
        send_beat(KIND_INTERVAL, 1);
        send_beat(KIND_INTERVAL, 0);
        send_beat(KIND_INTERVAL, INTERVAL_TOP);
        send_beat(KIND_INTERVAL, 40000);
        drain_and_settle();
        write_windows('0);
        send_beat(KIND_INTERVAL, 0);
        send_beat(KIND_INTERVAL, INTERVAL_TOP);
        send_beat(KIND_INTERVAL, 1);
        send_beat(KIND_READ,     0);
    endtask

    // Mostly whole frames with random content; the rest short frames, read
    // bursts and loose intervals
    task automatic test_random_traffic(input t_windows w, input bit quiet);
        int stop_at;
        int pick;
        drain_and_settle();
        write_windows(w);
        steady_mode = quiet;
        stop_at = beats_sent + RANDOM_BEATS;
        while (beats_sent < stop_at) begin
            pick = int'($urandom_range(0, 99));
            if (pick < 65) begin
                send_frame(FRAME_BITS);
                if ($urandom_range(0, 99) < 60)
                    send_beat(KIND_READ, $urandom_range(0, INTERVAL_TOP));
            end else if (pick < 75) begin
                send_frame($urandom_range(0, FRAME_BITS - 1));
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 3))
                    send_beat(KIND_READ, $urandom_range(0, INTERVAL_TOP));
            end else begin
                repeat ($urandom_range(1, 5))
                    send_beat(KIND_INTERVAL, $urandom_range(0, INTERVAL_TOP));
            end
        end
        steady_mode = 1'b0;
    endtask

    task automatic finish_run();
        drain_and_settle();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    endtask

    initial begin
        win         = '{hdr_lo: irpd_pkg::HeaderMinRst, hdr_hi: irpd_pkg::HeaderMaxRst,
                        zero_lo: irpd_pkg::ZeroMinRst, zero_hi: irpd_pkg::ZeroMaxRst,
                        one_lo: irpd_pkg::OneMinRst, one_hi: irpd_pkg::OneMaxRst};
        frame_byte  = '{default: '0};
        bits_in     = '0;
        frame_armed = 1'b0;
        code_ready  = 1'b0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_windows();
        test_window_overlap();
        test_extreme_windows();
        test_random_traffic('{hdr_lo: irpd_pkg::HeaderMinRst, hdr_hi: irpd_pkg::HeaderMaxRst,
                              zero_lo: irpd_pkg::ZeroMinRst, zero_hi: irpd_pkg::ZeroMaxRst,
                              one_lo: irpd_pkg::OneMinRst, one_hi: irpd_pkg::OneMaxRst},
                            1'b0);
        test_random_traffic(random_windows(), 1'b1);
        test_random_traffic(random_windows(), 1'b0);
        test_random_traffic(random_windows(), 1'b0);
        test_random_traffic(random_windows(), 1'b0);
        finish_run();
    end

endmodule
